// ----- design/bse_pkg.sv -----
// Shared types, constants and saturating helpers for the bond stretch unit.
package bse_pkg;

   localparam int ATOM_COUNT = 4096;
   localparam int MAG_W      = 62;
   localparam int SQRT_IN_W  = 52;
   localparam int ROOT_W     = 26;
   localparam int DVD_W      = 78;

   localparam logic signed [63:0] LIM        = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] Q_ONE      = 64'sd65536;
   localparam logic signed [63:0] Q_ONE_HALF = 64'sd98304;
   localparam logic signed [63:0] MAX48      = 64'sd140737488355327;
   localparam logic signed [63:0] MIN48      = -64'sd140737488355328;

   localparam logic signed [31:0] ENERGY_UNIT_RST   = 32'sd4714660;
   localparam logic signed [31:0] CUBIC_COEFF_RST   = -32'sd131072;
   localparam logic signed [31:0] QUARTIC_COEFF_RST = 32'sd152917;

   typedef enum logic [1:0] {
      REG_ENERGY_UNIT   = 2'd0,
      REG_CUBIC_COEFF   = 2'd1,
      REG_QUARTIC_COEFF = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_LAUNCH, ST_MUL, ST_ROOT_GO, ST_ROOT,
      ST_DIV_GO, ST_DIV, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_SQX, OP_SQY, OP_SQZ, OP_UK, OP_DT2, OP_T1, OP_T2, OP_H,
      OP_A1, OP_DED, OP_E0, OP_EN, OP_GX, OP_GY, OP_GZ
   } op_type;

   function automatic logic signed [63:0] addsat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (s > LIM) return LIM;
      if (s < -LIM) return -LIM;
      return s;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      if (v > MAX48) return MAX48[47:0];
      if (v < MIN48) return MIN48[47:0];
      return v[47:0];
   endfunction

   function automatic logic [MAG_W-1:0] mag62(input logic signed [63:0] v);
      logic [63:0] n;
      n = v[63] ? 64'(-v) : 64'(v);
      return n[MAG_W-1:0];
   endfunction

endpackage

// ----- design/bond_stretch_energy_gradient.sv -----
// Bond stretch energy and gradient unit: sequencer, shared serial units, result register.
// Usage:
//   Request channel (req_*): one bond per beat, taken when req_valid is high and
//   req_stall low. req_stall stays high while a bond is being worked on.
//   Response channel (rsp_*): one beat per bond with energy, gradient, the atom
//   indices and the running energy total; is_last marks the final total, after
//   which the total restarts from zero.
//   Configuration (csr_*): energy unit, cubic and quartic coefficients, written
//   while the unit is idle.
// Sequence:
//   An active bond with nonzero length takes fifteen multiplications on the
//   bit-serial multiplier, a square root and a division. A zero-length bond
//   skips the division and the gradient products; an inactive bond goes
//   from idle straight to the done state.
//   A new bond is taken while the previous response still waits in the output
//   register. If rsp_stall holds that register, the next result waits in the
//   done state and the request side stays stalled.
// Reset clears the energy total, the response valid and restores the register
// defaults.
module bond_stretch_energy_gradient (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [11:0]         req_atom_a,
   input  logic [11:0]         req_atom_b,
   input  logic signed [23:0]  req_xa,
   input  logic signed [23:0]  req_ya,
   input  logic signed [23:0]  req_za,
   input  logic signed [23:0]  req_xb,
   input  logic signed [23:0]  req_yb,
   input  logic signed [23:0]  req_zb,
   input  logic [19:0]         req_rest_length,
   input  logic [15:0]         req_force_const,
   input  logic                req_active,
   input  logic                req_last_bond,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [11:0]         rsp_out_atom_a,
   output logic [11:0]         rsp_out_atom_b,
   output logic signed [47:0]  rsp_bond_energy,
   output logic signed [47:0]  rsp_grad_x,
   output logic signed [47:0]  rsp_grad_y,
   output logic signed [47:0]  rsp_grad_z,
   output logic signed [47:0]  rsp_total_energy,
   output logic                rsp_is_last,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);
   import bse_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic mul_start, root_start, div_start, load, accept;
   logic mul_done, root_done, div_done;
   logic [2*MAG_W-1:0] prod;
   logic [ROOT_W-1:0]  root;
   logic [DVD_W-1:0]   quot;

   logic signed [31:0] u_ff, c_ff, q_ff;
   logic signed [47:0] sum_ff, nsum_in, e48_in;

   logic signed [24:0] dx_ff, dy_ff, dz_ff;
   logic [19:0]        rest_ff;
   logic [23:0]        k16_ff;
   logic [11:0]        a_ff, b_ff;
   logic               act_ff, last_ff, act_in, neg_ff;
   logic [SQRT_IN_W-1:0] r2_ff;
   logic [ROOT_W-1:0]  r_ff;
   logic signed [26:0] dt_ff;

   logic signed [63:0] uk_ff, dt2_ff, t1_ff, t2_ff, h_ff, a1_ff, ded_ff, e0_ff, en_ff;
   logic signed [63:0] de_ff, uk2_ff, p1_ff, poly_ff, tt_ff, h1_ff, dpoly_ff;
   logic signed [47:0] gx_ff, gy_ff, gz_ff;

   logic signed [63:0] opa_in, opb_in, mres_in, dres_in;
   logic [MAG_W-1:0]   mmag_in, dmag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         u_ff <= ENERGY_UNIT_RST;
         c_ff <= CUBIC_COEFF_RST;
         q_ff <= QUARTIC_COEFF_RST;
      end else if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_ENERGY_UNIT:   u_ff <= csr_data;
            REG_CUBIC_COEFF:   c_ff <= csr_data;
            REG_QUARTIC_COEFF: q_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign accept = req_valid && !req_stall;
   assign act_in = req_active && ({5'b0, req_atom_a} < 17'(ATOM_COUNT))
                   && ({5'b0, req_atom_b} < 17'(ATOM_COUNT));

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            state_in = act_in ? ST_PREP : ST_DONE;
            op_in    = OP_SQX;
         end
         ST_PREP:   state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_MUL;
         ST_MUL: if (mul_done) begin
            case (op_ff)
               OP_SQZ: state_in = ST_ROOT_GO;
               OP_EN:  state_in = (r_ff != '0) ? ST_DIV_GO : ST_DONE;
               OP_GZ:  state_in = ST_DONE;
               default: begin
                  state_in = ST_PREP;
                  op_in    = op_type'(op_ff + 4'd1);
               end
            endcase
         end
         ST_ROOT_GO: state_in = ST_ROOT;
         ST_ROOT: if (root_done) begin
            state_in = ST_PREP;
            op_in    = OP_UK;
         end
         ST_DIV_GO: state_in = ST_DIV;
         ST_DIV: if (div_done) begin
            state_in = ST_PREP;
            op_in    = OP_GX;
         end
         ST_DONE: if (!rsp_valid || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      mul_start  = 1'b0;
      root_start = 1'b0;
      div_start  = 1'b0;
      load       = 1'b0;
      case (state_ff)
         ST_IDLE:    req_stall  = 1'b0;
         ST_LAUNCH:  mul_start  = 1'b1;
         ST_ROOT_GO: root_start = 1'b1;
         ST_DIV_GO:  div_start  = 1'b1;
         ST_DONE:    load       = !rsp_valid || !rsp_stall;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_SQX;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // operand selection
   always_comb begin
      case (op_ff)
         OP_SQX:  begin opa_in = 64'(dx_ff);  opb_in = 64'(dx_ff); end
         OP_SQY:  begin opa_in = 64'(dy_ff);  opb_in = 64'(dy_ff); end
         OP_SQZ:  begin opa_in = 64'(dz_ff);  opb_in = 64'(dz_ff); end
         OP_UK:   begin opa_in = 64'(u_ff);   opb_in = 64'({1'b0, k16_ff}); end
         OP_DT2:  begin opa_in = 64'(dt_ff);  opb_in = 64'(dt_ff); end
         OP_T1:   begin opa_in = 64'(c_ff);   opb_in = 64'(dt_ff); end
         OP_T2:   begin opa_in = 64'(q_ff);   opb_in = dt2_ff; end
         OP_H:    begin opa_in = t1_ff;       opb_in = Q_ONE_HALF; end
         OP_A1:   begin opa_in = uk2_ff;      opb_in = 64'(dt_ff); end
         OP_DED:  begin opa_in = a1_ff;       opb_in = dpoly_ff; end
         OP_E0:   begin opa_in = uk_ff;       opb_in = dt2_ff; end
         OP_EN:   begin opa_in = e0_ff;       opb_in = poly_ff; end
         OP_GX:   begin opa_in = de_ff;       opb_in = 64'(dx_ff); end
         OP_GY:   begin opa_in = de_ff;       opb_in = 64'(dy_ff); end
         OP_GZ:   begin opa_in = de_ff;       opb_in = 64'(dz_ff); end
         default: begin opa_in = '0;          opb_in = '0; end
      endcase
   end

   bse_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a_mag (mag62(opa_in)), .b_mag (mag62(opb_in)),
      .done  (mul_done), .prod (prod)
   );

   bse_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (root_start),
      .value (r2_ff), .done (root_done), .root (root)
   );

   bse_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num_mag (mag62(ded_ff)), .den (r_ff),
      .done (div_done), .quot (quot)
   );

   // Q.16 rescale with saturation
   assign mmag_in = (|prod[2*MAG_W-1:MAG_W+16]) ? LIM[MAG_W-1:0] : prod[MAG_W+15:16];
   assign mres_in = neg_ff ? -64'({2'b0, mmag_in}) : 64'({2'b0, mmag_in});
   assign dmag_in = (|quot[DVD_W-1:MAG_W]) ? LIM[MAG_W-1:0] : quot[MAG_W-1:0];
   assign dres_in = ded_ff[63] ? -64'({2'b0, dmag_in}) : 64'({2'b0, dmag_in});

   always_ff @(posedge clock) begin
      uk2_ff   <= addsat(uk_ff, uk_ff);
      p1_ff    <= addsat(Q_ONE, t1_ff);
      poly_ff  <= addsat(p1_ff, t2_ff);
      tt_ff    <= addsat(t2_ff, t2_ff);
      h1_ff    <= addsat(Q_ONE, h_ff);
      dpoly_ff <= addsat(h1_ff, tt_ff);

      if (accept) begin
         dx_ff   <= {req_xa[23], req_xa} - {req_xb[23], req_xb};
         dy_ff   <= {req_ya[23], req_ya} - {req_yb[23], req_yb};
         dz_ff   <= {req_za[23], req_za} - {req_zb[23], req_zb};
         rest_ff <= req_rest_length;
         k16_ff  <= {req_force_const, 8'b0};
         a_ff    <= req_atom_a;
         b_ff    <= req_atom_b;
         act_ff  <= act_in;
         last_ff <= req_last_bond;
         r2_ff   <= '0;
         r_ff    <= '0;
         en_ff   <= '0;
         gx_ff   <= '0;
         gy_ff   <= '0;
         gz_ff   <= '0;
      end
      if (mul_start) neg_ff <= opa_in[63] ^ opb_in[63];
      if (root_done) begin
         r_ff  <= root;
         dt_ff <= $signed({1'b0, root}) - $signed({7'b0, rest_ff});
      end
      if (div_done) de_ff <= dres_in;
      if (state_ff == ST_MUL && mul_done) begin
         case (op_ff)
            OP_SQX, OP_SQY, OP_SQZ: r2_ff <= r2_ff + prod[SQRT_IN_W-1:0];
            OP_UK:  uk_ff  <= mres_in;
            OP_DT2: dt2_ff <= mres_in;
            OP_T1:  t1_ff  <= mres_in;
            OP_T2:  t2_ff  <= mres_in;
            OP_H:   h_ff   <= mres_in;
            OP_A1:  a1_ff  <= mres_in;
            OP_DED: ded_ff <= mres_in;
            OP_E0:  e0_ff  <= mres_in;
            OP_EN:  en_ff  <= mres_in;
            OP_GX:  gx_ff  <= sat48(mres_in);
            OP_GY:  gy_ff  <= sat48(mres_in);
            OP_GZ:  gz_ff  <= sat48(mres_in);
            default: ;
         endcase
      end
   end

   assign e48_in  = sat48(en_ff);
   assign nsum_in = sat48(64'(sum_ff) + 64'(e48_in));

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            sum_ff       <= last_ff ? '0 : nsum_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_out_atom_a   <= a_ff;
         rsp_out_atom_b   <= b_ff;
         rsp_bond_energy  <= e48_in;
         rsp_grad_x       <= gx_ff;
         rsp_grad_y       <= gy_ff;
         rsp_grad_z       <= gz_ff;
         rsp_total_energy <= nsum_in;
         rsp_is_last      <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall) else $error("request taken while busy");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> r_ff != '0) else $error("division by zero length");
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (load && last_ff) |=> sum_ff == '0) else $error("total not cleared");
   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      (load && !act_ff) |=> rsp_bond_energy == '0) else $error("inactive energy");
`endif
endmodule

// ----- design/bse_mul.sv -----
// Bit-serial shift-add multiplier for operand magnitudes, one bit per cycle.
module bse_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bse_pkg::MAG_W-1:0]     a_mag,
   input  logic [bse_pkg::MAG_W-1:0]     b_mag,
   output logic                          done,
   output logic [2*bse_pkg::MAG_W-1:0]   prod
);
   import bse_pkg::*;

   logic [MAG_W-1:0] a_ff, acc_ff, b_ff;
   logic [5:0]       cnt_ff;
   logic             run_ff, done_ff;
   logic [MAG_W:0]   sum_in;

   assign sum_in = {1'b0, acc_ff} + (b_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(MAG_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a_mag;
         b_ff   <= b_mag;
         acc_ff <= '0;
      end else if (run_ff) begin
         acc_ff <= sum_in[MAG_W:1];
         b_ff   <= {sum_in[0], b_ff[MAG_W-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = {acc_ff, b_ff};
endmodule

// ----- design/bse_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
module bse_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [bse_pkg::SQRT_IN_W-1:0]   value,
   output logic                            done,
   output logic [bse_pkg::ROOT_W-1:0]      root
);
   import bse_pkg::*;

   localparam int W = SQRT_IN_W + 1;

   logic [W-1:0] v_ff, res_ff, bit_ff, t_in;
   logic [4:0]   cnt_ff;
   logic         run_ff, done_ff;

   assign t_in = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(ROOT_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= W'(value);
         res_ff <= '0;
         bit_ff <= W'(1) << (2 * (ROOT_W - 1));
      end else if (run_ff) begin
         if (v_ff >= t_in) begin
            v_ff   <= v_ff - t_in;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];
endmodule

// ----- design/bse_div.sv -----
// Restoring divider, one quotient bit per cycle, dividend is numerator scaled by 2^16.
module bse_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bse_pkg::MAG_W-1:0]     num_mag,
   input  logic [bse_pkg::ROOT_W-1:0]    den,
   output logic                          done,
   output logic [bse_pkg::DVD_W-1:0]     quot
);
   import bse_pkg::*;

   logic [DVD_W-1:0]  dvd_ff;
   logic [ROOT_W-1:0] rem_ff, den_ff;
   logic [ROOT_W:0]   t_in;
   logic              ge_in;
   logic [6:0]        cnt_ff;
   logic              run_ff, done_ff;

   assign t_in  = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge_in = t_in >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'(DVD_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= {num_mag, 16'b0};
         rem_ff <= '0;
         den_ff <= den;
      end else if (run_ff) begin
         rem_ff <= ge_in ? ROOT_W'(t_in - {1'b0, den_ff}) : t_in[ROOT_W-1:0];
         dvd_ff <= {dvd_ff[DVD_W-2:0], ge_in};
      end
   end

   assign done = done_ff;
   assign quot = dvd_ff;
endmodule

// ----- tb/sv/bond_stretch_energy_gradient_test.sv -----
// Self-checking testbench for the bond stretch energy and gradient unit.
module bond_stretch_energy_gradient_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bse_pkg::*;

   localparam int STALL_LIMIT = 60000;
   localparam logic [127:0] LIM_WIDE = 128'h3FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [11:0]        atom_a;
      logic [11:0]        atom_b;
      logic signed [23:0] xa, ya, za, xb, yb, zb;
      logic [19:0]        rest_length;
      logic [15:0]        force_const;
      logic               active;
      logic               last_bond;
   } bond_type;

   typedef struct {
      logic [11:0] atom_a;
      logic [11:0] atom_b;
      logic [47:0] energy;
      logic [47:0] gx, gy, gz;
      logic [47:0] total;
      logic        is_last;
   } bond_result_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [11:0] req_atom_a, req_atom_b;
   logic signed [23:0] req_xa, req_ya, req_za, req_xb, req_yb, req_zb;
   logic [19:0] req_rest_length;
   logic [15:0] req_force_const;
   logic req_active, req_last_bond;
   logic rsp_valid, rsp_stall;
   logic [11:0] rsp_out_atom_a, rsp_out_atom_b;
   logic signed [47:0] rsp_bond_energy, rsp_grad_x, rsp_grad_y, rsp_grad_z;
   logic signed [47:0] rsp_total_energy;
   logic rsp_is_last;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [31:0] csr_data;

   bond_stretch_energy_gradient u_dut (.*);

   bond_type        pending_bonds[$];
   bond_result_type owed_results[$];
   bond_type        bond_on_bus;
   logic signed [63:0] unit_q, cubic_q, quartic_q, running_sum;
   int bonds_queued, bonds_taken, results_seen, mismatches, idle_cycles;
   int in_gap, out_gap, calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
      if (v > LIM) return LIM;
      if (v < -LIM) return -LIM;
      return v;
   endfunction

   function automatic logic [63:0] abs_q(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] sum_q(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      return clamp_q(clamp_q(a) + clamp_q(b));
   endfunction

   function automatic logic signed [63:0] mul_q(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic [127:0] p;
      logic neg;
      p = (128'(abs_q(clamp_q(a))) * 128'(abs_q(clamp_q(b)))) >> 16;
      neg = a[63] != b[63];
      if (p > LIM_WIDE) return neg ? -LIM : LIM;
      return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
   endfunction

   function automatic logic signed [63:0] div_by_length(input logic signed [63:0] n,
                                                        input logic [63:0] r);
      logic [127:0] quot;
      quot = {48'd0, abs_q(clamp_q(n)), 16'd0} / {64'd0, r};
      if (quot > LIM_WIDE) return n[63] ? -LIM : LIM;
      return n[63] ? -$signed(quot[63:0]) : $signed(quot[63:0]);
   endfunction

   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [63:0] clip48(input logic signed [63:0] v);
      if (v > MAX48) return MAX48;
      if (v < MIN48) return MIN48;
      return v;
   endfunction

   // Energy and gradient of one bond; updates the running total.
   task automatic bond_forecast(input bond_type b);
      bond_result_type res;
      logic signed [63:0] dx, dy, dz, dt, k16, uk, dt2, t1, t2, poly, dpoly, deddt, de, e;
      logic signed [63:0] g;
      logic [63:0] r2, r;
      res.atom_a = b.atom_a;
      res.atom_b = b.atom_b;
      res.energy = '0; res.gx = '0; res.gy = '0; res.gz = '0;
      res.is_last = b.last_bond;
      if (b.active && b.atom_a < ATOM_COUNT && b.atom_b < ATOM_COUNT) begin
         dx = 64'(b.xa) - 64'(b.xb);
         dy = 64'(b.ya) - 64'(b.yb);
         dz = 64'(b.za) - 64'(b.zb);
         r2 = abs_q(dx) * abs_q(dx) + abs_q(dy) * abs_q(dy) + abs_q(dz) * abs_q(dz);
         r = floor_root(r2);
         dt = $signed(r) - $signed({44'd0, b.rest_length});
         k16 = $signed({40'd0, b.force_const, 8'd0});
         uk = mul_q(unit_q, k16);
         dt2 = mul_q(dt, dt);
         t1 = mul_q(cubic_q, dt);
         t2 = mul_q(quartic_q, dt2);
         poly = sum_q(sum_q(Q_ONE, t1), t2);
         dpoly = sum_q(sum_q(Q_ONE, mul_q(t1, Q_ONE_HALF)), sum_q(t2, t2));
         deddt = mul_q(mul_q(sum_q(uk, uk), dt), dpoly);
         e = clip48(mul_q(mul_q(uk, dt2), poly));
         res.energy = e[47:0];
         if (r != 0) begin
            de = div_by_length(deddt, r);
            g = clip48(mul_q(de, dx));
            res.gx = g[47:0];
            g = clip48(mul_q(de, dy));
            res.gy = g[47:0];
            g = clip48(mul_q(de, dz));
            res.gz = g[47:0];
         end
         running_sum = clip48(running_sum + e);
      end
      res.total = running_sum[47:0];
      if (b.last_bond) running_sum = 0;
      owed_results.push_back(res);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm != 0 || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_bonds.size() > 0) begin
            bond_on_bus = pending_bonds.pop_front();
            req_atom_a <= bond_on_bus.atom_a;
            req_atom_b <= bond_on_bus.atom_b;
            req_xa <= bond_on_bus.xa; req_ya <= bond_on_bus.ya; req_za <= bond_on_bus.za;
            req_xb <= bond_on_bus.xb; req_yb <= bond_on_bus.yb; req_zb <= bond_on_bus.zb;
            req_rest_length <= bond_on_bus.rest_length;
            req_force_const <= bond_on_bus.force_const;
            req_active <= bond_on_bus.active;
            req_last_bond <= bond_on_bus.last_bond;
            req_valid <= 1'b1;
            in_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (out_gap > 0) begin
         out_gap <= out_gap - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         out_gap <= pick_gap();
      end
   end

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s at beat %0d: expected %h, got %h",
                     name, results_seen, want, got);
      end
   endtask

   // monitor and watchdog
   always @(posedge clock) begin
      bond_result_type want;
      logic moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            bond_forecast(bond_on_bus);
            bonds_taken++;
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (owed_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("response beat with nothing owed");
            end else begin
               want = owed_results.pop_front();
               check_field("out_atom_a", 48'(want.atom_a), 48'(rsp_out_atom_a));
               check_field("out_atom_b", 48'(want.atom_b), 48'(rsp_out_atom_b));
               check_field("bond_energy", want.energy, rsp_bond_energy);
               check_field("grad_x", want.gx, rsp_grad_x);
               check_field("grad_y", want.gy, rsp_grad_y);
               check_field("grad_z", want.gz, rsp_grad_z);
               check_field("total_energy", want.total, rsp_total_energy);
               check_field("is_last", 48'(want.is_last), 48'(rsp_is_last));
            end
            results_seen++;
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("bond_stretch_energy_gradient regression: fail");
            $finish;
         end
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_data = value;
      case (idx)
         REG_ENERGY_UNIT:   unit_q = 64'($signed(value));
         REG_CUBIC_COEFF:   cubic_q = 64'($signed(value));
         REG_QUARTIC_COEFF: quartic_q = 64'($signed(value));
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic add_bond(input bond_type b);
      pending_bonds.push_back(b);
      bonds_queued++;
   endtask

   function automatic bond_type plain_bond();
      bond_type b;
      b.atom_a = 12'($urandom); b.atom_b = 12'($urandom);
      b.xa = 24'($urandom); b.ya = 24'($urandom); b.za = 24'($urandom);
      b.xb = 24'($urandom); b.yb = 24'($urandom); b.zb = 24'($urandom);
      b.rest_length = 20'($urandom);
      b.force_const = 16'($urandom);
      b.active = 1'($urandom);
      b.last_bond = 1'($urandom);
      return b;
   endfunction

   // near-equilibrium bond with random content; some full-range noise
   function automatic bond_type random_bond();
      bond_type b;
      int roll;
      b = plain_bond();
      roll = $urandom_range(0, 99);
      if (roll >= 15) begin
         b.xa = $signed(24'($urandom_range(0, 8388607))) >>> 1;
         b.ya = $signed(24'($urandom_range(0, 8388607))) >>> 1;
         b.za = $signed(24'($urandom_range(0, 8388607))) >>> 1;
         b.xb = b.xa + 24'($signed(18'($urandom)));
         b.yb = b.ya + 24'($signed(18'($urandom)));
         b.zb = b.za + 24'($signed(18'($urandom)));
         if (roll < 20) begin
            b.xb = b.xa; b.yb = b.ya; b.zb = b.za;
         end
         b.rest_length = 20'($urandom_range(0, 262143));
         b.force_const = 16'($urandom_range(0, 4095));
         b.active = $urandom_range(0, 9) != 0;
         b.last_bond = $urandom_range(0, 19) == 0;
      end
      return b;
   endfunction

   task automatic drain();
      while (bonds_taken != bonds_queued || owed_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      bond_type b;
      reset = 1'b1;
      req_valid = 1'b0;
      req_atom_a = '0; req_atom_b = '0;
      req_xa = '0; req_ya = '0; req_za = '0; req_xb = '0; req_yb = '0; req_zb = '0;
      req_rest_length = '0; req_force_const = '0; req_active = 1'b0; req_last_bond = 1'b0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0; csr_index = REG_ENERGY_UNIT; csr_data = '0;
      in_gap = 0; out_gap = 0; calm = 0;
      bonds_queued = 0; bonds_taken = 0; results_seen = 0; mismatches = 0; idle_cycles = 0;
      unit_q = 64'(ENERGY_UNIT_RST);
      cubic_q = 64'(CUBIC_COEFF_RST);
      quartic_q = 64'(QUARTIC_COEFF_RST);
      running_sum = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: coordinate, length, constant and atom index extremes, zero length, inactive
      for (int i = 0; i < 22; i++) begin
         b = random_bond();
         b.active = 1'b1;
         b.last_bond = 1'b0;
         case (i)
            0: begin b.xa = 24'sh7FFFFF; b.xb = -24'sh800000; b.ya = 24'sh7FFFFF;
                      b.yb = -24'sh800000; b.za = 24'sh7FFFFF; b.zb = -24'sh800000;
                      b.force_const = 16'hFFFF; b.rest_length = '0; end
            1: begin b.xa = -24'sh800000; b.xb = 24'sh7FFFFF; b.ya = '0; b.yb = '0;
                      b.za = '0; b.zb = '0; b.rest_length = 20'hFFFFF; end
            2: begin b.xb = b.xa; b.yb = b.ya; b.zb = b.za; end
            3: begin b.xb = b.xa; b.yb = b.ya; b.zb = b.za; b.rest_length = 20'hFFFFF;
                      b.force_const = 16'hFFFF; end
            4: b.active = 1'b0;
            5: begin b.active = 1'b0; b.last_bond = 1'b1; end
            6: begin b.atom_a = 12'hFFF; b.atom_b = 12'h000; end
            7: begin b.atom_a = 12'h000; b.atom_b = 12'hFFF; b.last_bond = 1'b1; end
            8: b.force_const = '0;
            9: begin b.xa = 24'sh10000; b.xb = '0; b.ya = '0; b.yb = '0; b.za = '0;
                      b.zb = '0; b.rest_length = 20'h10000; end
            10: begin b.xa = '0; b.xb = '0; b.ya = '0; b.yb = '0; b.za = 24'sh1;
                       b.zb = '0; b.rest_length = '0; b.force_const = 16'hFFFF; end
            21: b.last_bond = 1'b1;
            default: ;
         endcase
         add_bond(b);
      end
      for (int i = 0; i < 140; i++) add_bond(random_bond());
      drain();

      // register extremes, then random settings
      for (int phase = 0; phase < 6; phase++) begin
         calm = (phase == 2);
         case (phase)
            0: begin write_reg(REG_ENERGY_UNIT, 32'h7FFF_FFFF);
                      write_reg(REG_CUBIC_COEFF, 32'h8000_0000);
                      write_reg(REG_QUARTIC_COEFF, 32'h7FFF_FFFF); end
            1: begin write_reg(REG_ENERGY_UNIT, 32'h8000_0000);
                      write_reg(REG_CUBIC_COEFF, 32'h0);
                      write_reg(REG_QUARTIC_COEFF, 32'h8000_0000); end
            2: begin write_reg(REG_ENERGY_UNIT, 32'h0);
                      write_reg(REG_CUBIC_COEFF, 32'h7FFF_FFFF);
                      write_reg(REG_QUARTIC_COEFF, 32'h0); end
            default: begin write_reg(REG_ENERGY_UNIT, $urandom);
                      write_reg(REG_CUBIC_COEFF, $urandom);
                      write_reg(REG_QUARTIC_COEFF, $urandom); end
         endcase
         for (int i = 0; i < 140; i++) add_bond(random_bond());
         add_bond(plain_bond());
         drain();
      end

      $display("%0d bonds taken, %0d response beats checked across seven register settings",
               bonds_taken, results_seen);
      if (mismatches == 0 && owed_results.size() == 0)
         $display("bond_stretch_energy_gradient regression: pass");
      else
         $display("bond_stretch_energy_gradient regression: fail");
      $finish;
   end

endmodule
